// ===== rtl/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared constants, codes and types of the sorted delay queue.
// ----------------------------------------------------------------------------
package sdq_pkg;

  // Slot pool and field widths.
  localparam int SLOTS      = 64;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int NEXT_W     = 7;
  localparam int TAG_W      = 16;
  localparam int DELAY_W    = 24;
  localparam int REM_W      = 26;
  localparam int STEP_W     = 8;
  localparam int SLOT_OUT_W = 6;
  localparam int KIND_W     = 2;

  // Link value that marks the end of the list.
  localparam logic [NEXT_W-1:0] NO_SLOT = 7'd127;

  // Stream word layouts.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_TICK_STEP = 1'd0;
  localparam logic [STEP_W-1:0] STEP_RESET = 8'd1;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_TICK     = 1'b1
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHEDULED = 2'd0,
    KIND_DROPPED   = 2'd1,
    KIND_EXPIRED   = 2'd2,
    KIND_NONE      = 2'd3
  } kind_e;

  // One result word.
  typedef struct packed {
    kind_e                  kind;
    logic [TAG_W-1:0]       tag;
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   last;
  } result_t;

endpackage

// ===== rtl/sdq_out_reg.sv =====
// ----------------------------------------------------------------------------
// sdq_out_reg
// Output register of the delay queue: holds one result word until the
// downstream side takes it, and can be refilled in the cycle it drains.
// ----------------------------------------------------------------------------
module sdq_out_reg import sdq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    can_push_o,
  output logic    out_valid_o,
  output result_t out_res_o,
  input  logic    out_ready_i
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // Room for a new word when empty or when the held word leaves now.
  assign can_push_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (push_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== rtl/sorted_delay_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_delay_queue_unit
// Time-ordered delay queue: a pool of slots linked in order of remaining
// delay, with schedule and tick commands and expiry results.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and is not ready until the
// last result of that command has been handed to the output register. A
// schedule walks the sorted list one entry at a time, a read state and a
// check state per entry, through the slot memory's registered read port,
// while a free-slot scan over the used bits runs alongside at one slot per
// cycle. A tick is one add to a running time base (deadlines are stored as
// absolute times, so no slot is touched), then a read and a check per
// entry up to the first one not due, with one expiry word per expired
// entry or a single nothing-due word. Output back-pressure stalls both
// commands while a result word waits. There is no clearing pass after
// reset: of the slot state, only the used bits are reset.
module sorted_delay_queue_unit import sdq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Command stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] payload_tag, [39:16] delay
  input  logic                   s_axis_tuser,  // [0] opcode
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] tag_out, [21:16] slot_out
  output logic [KIND_W-1:0]      m_axis_tuser,  // [1:0] kind
  output logic                   m_axis_tlast,  // last
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_WAIT_SCAN,
    S_LINK,
    S_LINK_PREV,
    S_POP_RD,
    S_POP_CHK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [REM_W-1:0] deadline;
  } slot_ent_t;

  state_e                state_q, state_d;
  logic [SLOTS-1:0]      used_q, used_d;
  logic [NEXT_W-1:0]     head_q, head_d;
  logic [REM_W-1:0]      now_q, now_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [TAG_W-1:0]      tag_q, tag_d;
  logic [DELAY_W-1:0]    delay_q, delay_d;
  logic [NEXT_W-1:0]     cur_q, cur_d;
  logic [NEXT_W-1:0]     prev_q, prev_d;
  logic [NEXT_W-1:0]     nxt_q, nxt_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  logic [IDX_W-1:0]      scan_q, scan_d;
  logic                  found_q, found_d;
  logic                  scan_end_q, scan_end_d;
  logic                  pend_v_q, pend_v_d;
  logic [TAG_W-1:0]      pend_tag_q, pend_tag_d;
  logic [IDX_W-1:0]      pend_slot_q, pend_slot_d;
  result_t               res_q, res_d;
  logic                  res_ret_q, res_ret_d;

  // Slot memories and their read data.
  slot_ent_t             dmem [SLOTS];
  logic [NEXT_W-1:0]     nmem [SLOTS];
  slot_ent_t             rd_ent_q;
  logic [NEXT_W-1:0]     rd_nxt_q;
  logic [IDX_W-1:0]      rd_idx;
  logic                  dm_we;
  logic                  nm_we;
  logic [IDX_W-1:0]      nm_waddr;
  logic [NEXT_W-1:0]     nm_wdata;

  logic                  in_acc;
  logic                  cfg_wr;
  logic                  cur_live;
  logic [REM_W-1:0]      rem;
  logic                  rem_lt;
  logic                  due;
  logic                  push;
  logic                  can_push;
  result_t               out_res;

  // An index is live when it lies inside the pool and its slot is in use.
  function automatic logic live(logic [NEXT_W-1:0] idx, logic [SLOTS-1:0] used);
    return (idx < NEXT_W'(SLOTS)) && used[idx[IDX_W-1:0]];
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign pready        = 1'b1;

  // Register read-back.
  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_TICK_STEP) begin
      prdata = APB_DATA_W'(step_q);
    end
  end

  assign rd_idx   = cur_q[IDX_W-1:0];
  assign cur_live = live(cur_q, used_q);

  // Remaining delay of the entry just read, against the time base.
  assign rem    = rd_ent_q.deadline - now_q;
  assign rem_lt = $signed(rem) < $signed({{(REM_W-DELAY_W){1'b0}}, delay_q});
  assign due    = rem[REM_W-1] || (rem == '0);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    head_d      = head_q;
    now_d       = now_q;
    step_d      = step_q;
    tag_d       = tag_q;
    delay_d     = delay_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    slot_d      = slot_q;
    scan_d      = scan_q;
    found_d     = found_q;
    scan_end_d  = scan_end_q;
    pend_v_d    = pend_v_q;
    pend_tag_d  = pend_tag_q;
    pend_slot_d = pend_slot_q;
    res_d       = res_q;
    res_ret_d   = res_ret_q;
    dm_we       = 1'b0;
    nm_we       = 1'b0;
    nm_waddr    = slot_q;
    nm_wdata    = nxt_q;
    push        = 1'b0;

    if (cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_TICK_STEP)) begin
      step_d = pwdata[STEP_W-1:0];
    end

    // Free-slot scan, one slot per cycle, alongside the list walk.
    if ((state_q == S_WALK_RD || state_q == S_WALK_CHK || state_q == S_WAIT_SCAN)
        && !scan_end_q) begin
      if (!used_q[scan_q]) begin
        found_d    = 1'b1;
        slot_d     = scan_q;
        scan_end_d = 1'b1;
      end else if (scan_q == IDX_W'(SLOTS - 1)) begin
        scan_end_d = 1'b1;
      end else begin
        scan_d = scan_q + 1'b1;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cur_d = head_q;
          if (s_axis_tuser == OP_SCHEDULE) begin
            tag_d      = s_axis_tdata[TAG_W-1:0];
            delay_d    = s_axis_tdata[TAG_W +: DELAY_W];
            prev_d     = NO_SLOT;
            scan_d     = '0;
            found_d    = 1'b0;
            scan_end_d = 1'b0;
            state_d    = S_WALK_RD;
          end else begin
            now_d    = now_q + REM_W'(step_q);
            pend_v_d = 1'b0;
            state_d  = S_POP_RD;
          end
        end
      end

      S_WALK_RD: begin
        if (cur_live) begin
          state_d = S_WALK_CHK;
        end else begin
          nxt_d   = NO_SLOT;
          state_d = S_WAIT_SCAN;
        end
      end

      // Step past entries that expire strictly earlier than the new one.
      S_WALK_CHK: begin
        if (rem_lt) begin
          prev_d  = cur_q;
          cur_d   = rd_nxt_q;
          state_d = S_WALK_RD;
        end else begin
          nxt_d   = cur_q;
          state_d = S_WAIT_SCAN;
        end
      end

      S_WAIT_SCAN: begin
        if (scan_end_q) begin
          if (found_q) begin
            state_d = S_LINK;
          end else begin
            res_d     = '{kind: KIND_DROPPED, tag: '0, slot: '0, last: 1'b1};
            res_ret_d = 1'b0;
            state_d   = S_EMIT;
          end
        end
      end

      // Write the new entry and its link; splice it in at the head when it has no predecessor.
      S_LINK: begin
        dm_we          = 1'b1;
        nm_we          = 1'b1;
        used_d[slot_q] = 1'b1;
        res_d     = '{kind: KIND_SCHEDULED, tag: '0, slot: SLOT_OUT_W'(slot_q),
                      last: 1'b1};
        res_ret_d = 1'b0;
        if (prev_q == NO_SLOT) begin
          head_d  = NEXT_W'(slot_q);
          state_d = S_EMIT;
        end else begin
          state_d = S_LINK_PREV;
        end
      end

      // Point the predecessor at the new entry.
      S_LINK_PREV: begin
        nm_we    = 1'b1;
        nm_waddr = prev_q[IDX_W-1:0];
        nm_wdata = NEXT_W'(slot_q);
        state_d  = S_EMIT;
      end

      S_POP_RD: begin
        if (cur_live) begin
          state_d = S_POP_CHK;
        end else begin
          head_d = NO_SLOT;
          if (pend_v_q) begin
            res_d = '{kind: KIND_EXPIRED, tag: pend_tag_q,
                      slot: SLOT_OUT_W'(pend_slot_q), last: 1'b1};
          end else begin
            res_d = '{kind: KIND_NONE, tag: '0, slot: '0, last: 1'b1};
          end
          res_ret_d = 1'b0;
          state_d   = S_EMIT;
        end
      end

      // Pop a due head; the previous pop is sent once it is known not last.
      S_POP_CHK: begin
        if (due) begin
          used_d[rd_idx] = 1'b0;
          head_d         = rd_nxt_q;
          cur_d          = rd_nxt_q;
          pend_v_d       = 1'b1;
          pend_tag_d     = rd_ent_q.tag;
          pend_slot_d    = rd_idx;
          if (pend_v_q) begin
            res_d     = '{kind: KIND_EXPIRED, tag: pend_tag_q,
                          slot: SLOT_OUT_W'(pend_slot_q), last: 1'b0};
            res_ret_d = 1'b1;
            state_d   = S_EMIT;
          end else begin
            state_d = S_POP_RD;
          end
        end else begin
          if (pend_v_q) begin
            res_d = '{kind: KIND_EXPIRED, tag: pend_tag_q,
                      slot: SLOT_OUT_W'(pend_slot_q), last: 1'b1};
          end else begin
            res_d = '{kind: KIND_NONE, tag: '0, slot: '0, last: 1'b1};
          end
          res_ret_d = 1'b0;
          state_d   = S_EMIT;
        end
      end

      S_EMIT: begin
        if (can_push) begin
          push    = 1'b1;
          state_d = res_ret_q ? S_POP_RD : S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      head_q    <= NO_SLOT;
      now_q     <= '0;
      step_q    <= STEP_RESET;
      pend_v_q  <= 1'b0;
      res_ret_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      head_q    <= head_d;
      now_q     <= now_d;
      step_q    <= step_d;
      pend_v_q  <= pend_v_d;
      res_ret_q <= res_ret_d;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk_i) begin
    tag_q       <= tag_d;
    delay_q     <= delay_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    nxt_q       <= nxt_d;
    slot_q      <= slot_d;
    scan_q      <= scan_d;
    found_q     <= found_d;
    scan_end_q  <= scan_end_d;
    pend_tag_q  <= pend_tag_d;
    pend_slot_q <= pend_slot_d;
    res_q       <= res_d;
  end

  // Slot memory: tag and absolute deadline.
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[slot_q] <= '{tag: tag_q, deadline: now_q + REM_W'(delay_q)};
    end
    rd_ent_q <= dmem[rd_idx];
  end

  // Link memory.
  always_ff @(posedge clk_i) begin
    if (nm_we) begin
      nmem[nm_waddr] <= nm_wdata;
    end
    rd_nxt_q <= nmem[rd_idx];
  end

  sdq_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res_q),
    .can_push_o  (can_push),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-TAG_W-SLOT_OUT_W){1'b0}}, out_res.slot, out_res.tag};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

// ===== rtl/sdq_checker.sv =====
// ----------------------------------------------------------------------------
// sdq_port_checks
// Port-level checks of the delay queue, bound to the top level.
// ----------------------------------------------------------------------------
module sdq_port_checks import sdq_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [KIND_W-1:0]      m_axis_tuser,
  input logic                   m_axis_tlast,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [APB_ADDR_W-1:0]  paddr,
  input logic [APB_DATA_W-1:0]  pwdata,
  input logic [APB_DATA_W-1:0]  prdata,
  input logic                   pready
);

  // A command word is worked on alone: no second word right behind it.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted back to back");

  // Only expiry words may be followed by more words of the same command.
  a_single_word_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_EXPIRED) |-> m_axis_tlast)
    else $error("non-expiry result without last");

  // Tag is only carried by expiry words.
  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_EXPIRED) |-> m_axis_tdata[TAG_W-1:0] == '0)
    else $error("tag on a non-expiry result");

  // Drop and nothing-due words name no slot.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DROPPED || m_axis_tuser == KIND_NONE)
    |-> m_axis_tdata[TAG_W +: SLOT_OUT_W] == '0)
    else $error("slot on a drop or nothing-due result");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

endmodule

bind sorted_delay_queue_unit sdq_port_checks u_sdq_port_checks (.*);
